FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the list store checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define LMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define LMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg
// word formats and codes of the multi list indexed store
// ----------------------------------------------------------------------------
package lms_pkg;

  // field widths fixed by the word formats
  localparam int OP_W        = 2;
  localparam int SEL_FIELD_W = 3;
  localparam int POS_FIELD_W = 6;
  localparam int HANDLE_W    = 32;
  localparam int STAT_W      = 2;
  localparam int LEN_FIELD_W = 7;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_LENGTH = 2'd3
  } op_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } stat_t;

  // input word
  typedef struct packed {
    op_t                    operation;
    logic [SEL_FIELD_W-1:0] list_select;
    logic [POS_FIELD_W-1:0] position;
    logic [HANDLE_W-1:0]    entry_value;
  } in_word_t;

  // result word
  typedef struct packed {
    stat_t                  status;
    logic [HANDLE_W-1:0]    read_value;
    logic [LEN_FIELD_W-1:0] list_length;
  } out_word_t;

endpackage

FILE: hw/rtl/lms_entry_ram.sv
// ----------------------------------------------------------------------------
// lms_entry_ram
// simple dual port entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lms_entry_ram #(
  parameter int DEPTH = 512,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/lms_len_table.sv
// ----------------------------------------------------------------------------
// lms_len_table
// per list length memory with valid bits, unwritten lists read as empty
// ----------------------------------------------------------------------------
module lms_len_table #(
  parameter int NUM_LISTS = 8,
  parameter int LEN_W     = 7
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            rd_en,
  input  logic [((NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1)-1:0] rd_addr,
  output logic [LEN_W-1:0]                                rd_len,
  input  logic                                            wr_en,
  input  logic [((NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1)-1:0] wr_addr,
  input  logic [LEN_W-1:0]                                wr_len
);

  logic [LEN_W-1:0]     len_mem [NUM_LISTS];
  logic [NUM_LISTS-1:0] vld_r;
  logic [LEN_W-1:0]     q_r;
  logic                 q_vld_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      len_mem[wr_addr] <= wr_len;
    end
  end

  // valid bits, cleared at once by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= len_mem[rd_addr];
    end
  end

  assign rd_len = q_vld_r ? q_r : '0;

endmodule

FILE: hw/rtl/multi_list_indexed_store_unit.sv
// ----------------------------------------------------------------------------
// multi_list_indexed_store_unit: append, delete, read and length on lists
// sequence: length lookup (skipped on a bad list select), read wait or entry shift,
// then result register; a new word is taken only in idle, after the last result
// is handed on; the single entry memory write port moves one entry per cycle
// reset: all lists empty at once, no clearing pass, result register empty
// ----------------------------------------------------------------------------
module multi_list_indexed_store_unit #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lms_pkg::in_word_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lms_pkg::out_word_t out_data
);

  localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
  localparam int SEL_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int SX_W   = (SEL_W > lms_pkg::SEL_FIELD_W) ? SEL_W : lms_pkg::SEL_FIELD_W;
  localparam int CW     = (LEN_W > lms_pkg::LEN_FIELD_W) ? LEN_W : lms_pkg::LEN_FIELD_W;
  localparam int EDEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int EA_W   = $clog2(EDEPTH);
  localparam int LSW    = lms_pkg::LEN_FIELD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_SHIFT,
    S_RDWAIT,
    S_DONE
  } state_t;

  state_t                      state_r, state_nxt;
  lms_pkg::op_t                op_r, op_nxt;
  logic [SEL_W-1:0]            sel_r, sel_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic [lms_pkg::HANDLE_W-1:0] val_r, val_nxt;
  logic [EA_W-1:0]             base_r, base_nxt;
  logic [EA_W-1:0]             sh_rd_ea_r, sh_rd_ea_nxt;
  logic [EA_W-1:0]             sh_wr_ea_r, sh_wr_ea_nxt;
  logic [EA_W-1:0]             sh_end_ea_r, sh_end_ea_nxt;
  lms_pkg::out_word_t          res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lms_pkg::out_word_t          out_data_r, out_data_nxt;

  logic                        in_accept;
  logic [SX_W-1:0]             sel_x;
  logic                        sel_ok;

  // length table port
  logic                        len_rd_en;
  logic [SEL_W-1:0]            len_rd_addr;
  logic [LEN_W-1:0]            len_rd_len;
  logic                        len_wr_en;
  logic [LEN_W-1:0]            len_wr_len;

  // entry memory port
  logic                        ram_we;
  logic [EA_W-1:0]             ram_waddr;
  logic [lms_pkg::HANDLE_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [EA_W-1:0]             ram_raddr;
  logic [lms_pkg::HANDLE_W-1:0] ram_rdata;

  // current length in compare width, and lengths as reported
  logic [CW-1:0]               cur_len_x;
  logic [CW-1:0]               dec_len_x;
  logic [CW-1:0]               inc_len_x;
  logic [EA_W-1:0]             pos_ea;

  assign in_accept   = in_valid && in_ready;
  assign in_ready    = (state_r == S_IDLE);
  assign sel_x       = SX_W'(in_data.list_select);
  assign sel_ok      = (LSW'(in_data.list_select) < LSW'(NUM_LISTS)) ||
                       (NUM_LISTS >= (1 << lms_pkg::SEL_FIELD_W));
  assign len_rd_en   = in_accept && sel_ok;
  assign len_rd_addr = sel_x[SEL_W-1:0];

  assign cur_len_x = CW'(len_rd_len);
  assign dec_len_x = cur_len_x - CW'(1);
  assign inc_len_x = cur_len_x + CW'(1);
  assign pos_ea    = EA_W'(pos_r);

  lms_len_table #(
    .NUM_LISTS (NUM_LISTS),
    .LEN_W     (LEN_W)
  ) u_len_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (len_rd_en),
    .rd_addr (len_rd_addr),
    .rd_len  (len_rd_len),
    .wr_en   (len_wr_en),
    .wr_addr (sel_r),
    .wr_len  (len_wr_len)
  );

  lms_entry_ram #(
    .DEPTH (EDEPTH),
    .DW    (lms_pkg::HANDLE_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: length lookup, then append, shift, read or report
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    sel_nxt       = sel_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    base_nxt      = base_r;
    sh_rd_ea_nxt  = sh_rd_ea_r;
    sh_wr_ea_nxt  = sh_wr_ea_r;
    sh_end_ea_nxt = sh_end_ea_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    len_wr_en     = 1'b0;
    len_wr_len    = len_rd_len;
    ram_we        = 1'b0;
    ram_waddr     = base_r + EA_W'(len_rd_len);
    ram_wdata     = val_r;
    ram_re        = 1'b0;
    ram_raddr     = base_r + pos_ea;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt   = in_data.operation;
          sel_nxt  = sel_x[SEL_W-1:0];
          pos_nxt  = CW'(in_data.position);
          val_nxt  = in_data.entry_value;
          base_nxt = EA_W'(sel_x[SEL_W-1:0]) * EA_W'(LIST_DEPTH);
          if (sel_ok) begin
            state_nxt = S_LEN;
          end else begin
            res_nxt.status      = lms_pkg::ST_RANGE;
            res_nxt.read_value  = '0;
            res_nxt.list_length = '0;
            state_nxt           = S_DONE;
          end
        end
      end

      S_LEN: begin
        res_nxt.status      = lms_pkg::ST_OK;
        res_nxt.read_value  = '0;
        res_nxt.list_length = cur_len_x[LSW-1:0];
        state_nxt           = S_DONE;
        case (op_r)
          lms_pkg::OP_APPEND: begin
            if (val_r == '0) begin
              res_nxt.status = lms_pkg::ST_NULL;
            end else if (cur_len_x >= CW'(LIST_DEPTH)) begin
              res_nxt.status = lms_pkg::ST_FULL;
            end else begin
              ram_we              = 1'b1;
              len_wr_en           = 1'b1;
              len_wr_len          = inc_len_x[LEN_W-1:0];
              res_nxt.list_length = inc_len_x[LSW-1:0];
            end
          end
          lms_pkg::OP_DELETE: begin
            if (pos_r >= cur_len_x) begin
              res_nxt.status = lms_pkg::ST_RANGE;
            end else begin
              len_wr_en           = 1'b1;
              len_wr_len          = dec_len_x[LEN_W-1:0];
              res_nxt.list_length = dec_len_x[LSW-1:0];
              // later entries move down one place, read runs one ahead of write
              if ((pos_r + CW'(1)) < cur_len_x) begin
                ram_re        = 1'b1;
                ram_raddr     = base_r + pos_ea + EA_W'(1);
                sh_wr_ea_nxt  = base_r + pos_ea;
                sh_rd_ea_nxt  = base_r + pos_ea + EA_W'(2);
                sh_end_ea_nxt = base_r + EA_W'(len_rd_len);
                state_nxt     = S_SHIFT;
              end
            end
          end
          lms_pkg::OP_READ: begin
            if (pos_r >= cur_len_x) begin
              res_nxt.status = lms_pkg::ST_RANGE;
            end else begin
              ram_re    = 1'b1;
              state_nxt = S_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end

      S_SHIFT: begin
        // write back the entry read last cycle, fetch the next one
        ram_we       = 1'b1;
        ram_waddr    = sh_wr_ea_r;
        ram_wdata    = ram_rdata;
        sh_wr_ea_nxt = sh_wr_ea_r + EA_W'(1);
        if (sh_rd_ea_r != sh_end_ea_r) begin
          ram_re       = 1'b1;
          ram_raddr    = sh_rd_ea_r;
          sh_rd_ea_nxt = sh_rd_ea_r + EA_W'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RDWAIT: begin
        res_nxt.read_value = ram_rdata;
        state_nxt          = S_DONE;
      end

      S_DONE: begin
        // hand the word to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    sel_r       <= sel_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    base_r      <= base_nxt;
    sh_rd_ea_r  <= sh_rd_ea_nxt;
    sh_wr_ea_r  <= sh_wr_ea_nxt;
    sh_end_ea_r <= sh_end_ea_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/lms_checker.sv
// ----------------------------------------------------------------------------
// lms_checker
// port level checks of the multi list indexed store, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lms_checker #(
  parameter int LIST_DEPTH = 64
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lms_pkg::out_word_t out_data
);

  localparam logic [lms_pkg::LEN_FIELD_W-1:0] FULL_LEN =
    lms_pkg::LEN_FIELD_W'(LIST_DEPTH);

  // a stalled result word holds
  `LMS_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result word changed while stalled")

  // only a successful read carries data
  `LMS_ASSERT(a_rd_zero, (out_valid && out_data.status != lms_pkg::ST_OK) |-> (out_data.read_value == '0), "read value nonzero on error")

  // a full list reports the full depth
  `LMS_ASSERT(a_full_len, (out_valid && out_data.status == lms_pkg::ST_FULL) |-> (out_data.list_length == FULL_LEN), "full status with wrong length")

  // one word at a time: busy right after an accept
  `LMS_ASSERT(a_busy, (in_valid && in_ready) |=> !in_ready, "word accepted on back to back cycles")

  // reset empties the result register
  `LMS_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind multi_list_indexed_store_unit lms_checker #(.LIST_DEPTH(LIST_DEPTH)) u_lms_checker (.*);
